// ===== sv/ltge_pkg.sv =====
// Shared types and constants for the torus life generation engine.
package ltge_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_W     = 7;   // config register width
    localparam int CFG_IDX_W = 2;   // config register index width
    localparam int COORD_W   = 6;   // col / row field width
    localparam int ACT_W     = 2;   // action code width
    localparam int CNT_W     = 4;   // neighbor count width

    localparam int MIN_SIZE      = 3;
    localparam int SURVIVE_COUNT = 2;
    localparam int BIRTH_COUNT   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] RST_GRID_HEIGHT = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               cell_in;
    } t_cmd;

    typedef struct packed {
        logic             cell_out;
        logic [ACT_W-1:0] action_done;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_RMW,
        ST_STEP,
        ST_DRAIN
    } t_state;

endpackage

// ===== sv/life_torus_generation_engine_unit.sv =====
// Torus life engine top: grid RAM, coordinate wrap units, row sequencer.
// A write or read passes the col/row wrap, done flag, RAM read, modify and
// output register; an unused action is answered straight from idle. A
// generation reads one row per cycle through the single grid RAM read port
// (h = rows in use). One command at a time; busy is high while a command is
// in flight. Reset (synchronous, active low) runs a clearing pass over every
// grid RAM row with busy high; results cannot be stalled by the receiver.
module life_torus_generation_engine_unit import ltge_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    // result channel, one-cycle strobe
    output logic                 o_done,
    output t_result              o_result,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);        // column index
    localparam int WW  = $clog2(MAX_WIDTH + 1);    // width in use
    localparam int AW  = $clog2(MAX_HEIGHT);       // row address
    localparam int HW  = $clog2(MAX_HEIGHT + 1);   // height in use
    localparam int KW  = $clog2(MAX_HEIGHT + 2);   // step slot counter
    localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

    // ------------------------------------------------------------------
    // config registers and clamped sizes
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic [WW-1:0]    w_use;
    logic [HW-1:0]    h_use;

    always_comb begin
        if (r_grid_width < CFG_W'(MIN_SIZE)) begin
            w_use = WW'(MIN_SIZE);
        end else if (r_grid_width > CFG_W'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(r_grid_width);
        end
    end

    always_comb begin
        if (r_grid_height < CFG_W'(MIN_SIZE)) begin
            h_use = HW'(MIN_SIZE);
        end else if (HCW'(r_grid_height) > HCW'(MAX_HEIGHT)) begin
            h_use = HW'(MAX_HEIGHT);
        end else begin
            h_use = HW'(r_grid_height);
        end
    end

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic                  accept;

    logic                  lane_start;
    logic                  col_done, row_done;
    logic [WW-1:0]         col_rem;
    logic [HW-1:0]         row_rem;
    logic [XW-1:0]         cx;
    logic [AW-1:0]         cy;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MAX_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [MAX_WIDTH-1:0]  ram_rdata;
    logic [MAX_WIDTH-1:0]  row_mod;

    logic [AW-1:0]         r_clr_addr;
    logic [KW-1:0]         r_k;
    logic                  step_last_slot;
    logic                  slot_rd;
    logic                  r_s1_vld;
    logic                  r_s1_inj;
    logic [KW-1:0]         r_s1_k;
    logic [MAX_WIDTH-1:0]  r_up, r_mid, r_dn, r_row0;
    logic [MAX_WIDTH-1:0]  win_src;
    logic                  r_win_vld;
    logic [AW-1:0]         r_wy;
    logic                  last_wr;
    logic [MAX_WIDTH-1:0]  new_row;

    logic                  out_set;
    t_result               out_val;
    logic                  r_out_vld;
    t_result               r_result;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // col mod width, row mod height; both lanes finish together
    // ------------------------------------------------------------------
    assign lane_start = accept && ((i_cmd.action == ACT_WRITE) || (i_cmd.action == ACT_READ));

    ltge_modlane #(.DW(WW)) u_col_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_dividend (i_cmd.col),
        .i_divisor  (w_use),
        .o_done     (col_done),
        .o_rem      (col_rem)
    );

    ltge_modlane #(.DW(HW)) u_row_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_dividend (i_cmd.row),
        .i_divisor  (h_use),
        .o_done     (row_done),
        .o_rem      (row_rem)
    );

    // remainders hold until the next start
    assign cx = col_rem[XW-1:0];
    assign cy = row_rem[AW-1:0];

    // ------------------------------------------------------------------
    // grid RAM: one row per entry, bit x is column x
    // ------------------------------------------------------------------
    ltge_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // generation sequencer
    // Slot 0 reads row h-1, slots 1..h read rows 0..h-1, slot h+1 feeds the
    // saved original row 0 back in as the bottom neighbor of row h-1.
    // Each arriving row shifts the up/mid/dn window; once three rows are in,
    // the new row y is written back in place. Row y is only read again as
    // "up" for y+1, which the window already holds, so no scratch copy.
    // ------------------------------------------------------------------
    assign step_last_slot = (r_k == KW'(KW'(h_use) + KW'(1)));
    assign slot_rd        = (r_state == ST_STEP) && !step_last_slot;
    assign win_src        = r_s1_inj ? r_row0 : ram_rdata;
    assign last_wr        = r_win_vld && (r_wy == AW'(h_use - 1'b1));

    ltge_rowcalc #(.MAX_WIDTH(MAX_WIDTH)) u_rowcalc (
        .i_up    (r_up),
        .i_mid   (r_mid),
        .i_dn    (r_dn),
        .i_width (w_use),
        .o_next  (new_row)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(MAX_HEIGHT - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        ACT_WRITE, ACT_READ: n_state = ST_MOD;
                        ACT_STEP:            n_state = ST_STEP;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MOD: begin
                if (col_done) n_state = ST_RD;
            end
            ST_RD:  n_state = ST_RMW;
            ST_RMW: n_state = ST_IDLE;
            ST_STEP: begin
                if (step_last_slot) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (last_wr) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        row_mod     = ram_rdata;
        row_mod[cx] = r_cmd.cell_in;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cy;
        ram_wdata = row_mod;
        ram_raddr = cy;
        out_set   = 1'b0;
        out_val   = '{cell_out: 1'b0, action_done: r_cmd.action};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                // unused action answers at once and touches nothing
                if (accept && (i_cmd.action == ACT_NOP)) begin
                    out_set = 1'b1;
                    out_val = '{cell_out: 1'b0, action_done: i_cmd.action};
                end
            end
            ST_RMW: begin
                out_set = 1'b1;
                if (r_cmd.action == ACT_WRITE) begin
                    ram_we = 1'b1;
                end else begin
                    out_val.cell_out = ram_rdata[cx];
                end
            end
            ST_STEP: begin
                if (r_k == '0) begin
                    ram_raddr = AW'(h_use - 1'b1);
                end else begin
                    ram_raddr = AW'(r_k - 1'b1);
                end
            end
            ST_DRAIN: begin
                out_set = last_wr;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        // window write-back, only live during a generation
        if (r_win_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_wy;
            ram_wdata = new_row;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_k           <= '0;
            r_s1_vld      <= 1'b0;
            r_win_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= (r_state == ST_CLEAR) ? r_clr_addr + 1'b1 : '0;
            r_k        <= (r_state == ST_STEP) ? r_k + 1'b1 : '0;
            r_s1_vld   <= (r_state == ST_STEP);
            r_win_vld  <= r_s1_vld && (r_s1_k >= KW'(2));
            r_out_vld  <= out_set;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GRID_WIDTH)  r_grid_width  <= i_cfg_data;
                if (i_cfg_idx == REG_GRID_HEIGHT) r_grid_height <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_s1_inj <= step_last_slot;
        r_s1_k   <= r_k;
        if (r_s1_vld) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= win_src;
            if (r_s1_k == KW'(1)) begin
                r_row0 <= ram_rdata;
            end
        end
        r_wy <= AW'(r_s1_k - KW'(2));
        if (out_set) begin
            r_result <= out_val;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // in-place write-back never hits the row being fetched in the same cycle
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot_rd && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("grid write collides with row fetch");

    // window write-back only while a generation runs
    a_win_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_vld |-> ((r_state == ST_STEP) || (r_state == ST_DRAIN)))
        else $error("row write-back outside generation");

    // both wrap lanes finish on the same cycle
    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_done == row_done)
        else $error("col/row wrap lanes out of step");

    // a command beat other than the unused action keeps the block busy
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.action != ACT_NOP)) |=> busy)
        else $error("busy not raised after command beat");

endmodule

// ===== sv/ltge_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module ltge_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ltge_modlane.sv =====
// Restoring remainder unit: coordinate modulo grid size, one bit per cycle.
module ltge_modlane import ltge_pkg::*; #(
    parameter int DW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [DW-1:0]      i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_rem
);

    localparam int CW = $clog2(COORD_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [COORD_W-1:0] r_src;
    logic [DW-1:0]      r_rem;
    logic [DW:0]        trial;
    logic [DW-1:0]      n_rem;

    // remainder stays below the divisor, so trial < 2*divisor
    always_comb begin
        trial = {r_rem, r_src[COORD_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = DW'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(COORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_src <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_src <= {r_src[COORD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/ltge_rowcalc.sv =====
// B3/S23 next-row logic for one row from its three-row window, wrapped columns.
module ltge_rowcalc import ltge_pkg::*; #(
    parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic [MAX_WIDTH-1:0] i_up,
    input  logic [MAX_WIDTH-1:0] i_mid,
    input  logic [MAX_WIDTH-1:0] i_dn,
    input  logic [WW-1:0]        i_width,
    output logic [MAX_WIDTH-1:0] o_next
);

    logic [XW-1:0] last;
    logic          up_last;
    logic          mid_last;
    logic          dn_last;

    assign last     = XW'(i_width - 1'b1);
    assign up_last  = i_up[last];
    assign mid_last = i_mid[last];
    assign dn_last  = i_dn[last];

    for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
        logic             left_up, left_mid, left_dn;
        logic             right_up, right_mid, right_dn;
        logic             is_last;
        logic [CNT_W-1:0] n;
        logic             live;

        assign is_last = (last == XW'(x));

        if (x == 0) begin : g_left_wrap
            assign left_up  = up_last;
            assign left_mid = mid_last;
            assign left_dn  = dn_last;
        end else begin : g_left
            assign left_up  = i_up[x-1];
            assign left_mid = i_mid[x-1];
            assign left_dn  = i_dn[x-1];
        end

        // top column is always the last one in use when it is in use
        if (x == MAX_WIDTH - 1) begin : g_right_wrap
            assign right_up  = i_up[0];
            assign right_mid = i_mid[0];
            assign right_dn  = i_dn[0];
        end else begin : g_right
            assign right_up  = is_last ? i_up[0]  : i_up[x+1];
            assign right_mid = is_last ? i_mid[0] : i_mid[x+1];
            assign right_dn  = is_last ? i_dn[0]  : i_dn[x+1];
        end

        assign n = CNT_W'(left_up) + CNT_W'(i_up[x]) + CNT_W'(right_up)
                 + CNT_W'(left_mid) + CNT_W'(right_mid)
                 + CNT_W'(left_dn) + CNT_W'(i_dn[x]) + CNT_W'(right_dn);

        assign live = (n == CNT_W'(BIRTH_COUNT))
                   || (i_mid[x] && (n == CNT_W'(SURVIVE_COUNT)));

        // columns outside the active width keep their value
        assign o_next[x] = (WW'(x) < i_width) ? live : i_mid[x];
    end

endmodule
